// ----- hw/rtl/assert_macros.svh -----
// assertion macros for the polygon perimeter and area block
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define PPA_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("ppa assertion failed");

// condition must never be true outside reset
`define PPA_ASSERT_NEVER(label, clk, rst_n, cond) \
	`PPA_ASSERT(label, clk, rst_n, !(cond))

`endif

// ----- hw/rtl/ppa_pkg.sv -----
// shared types and constants for the polygon perimeter and area block
// no dependencies; used by the front, edge queue and back modules
package ppa_pkg;

	localparam int XW      = 24;
	localparam int DW      = XW + 1;
	localparam int PW      = 2 * DW;
	localparam int CNT_W   = 11;
	localparam int PERIM_W = 23;
	localparam int AREA_W  = 36;
	localparam int VCNT_W  = 7;
	localparam int CROSS_W = 39;

	localparam logic [1:0] MS_DXX = 2'd0;
	localparam logic [1:0] MS_DYY = 2'd1;
	localparam logic [1:0] MS_AB  = 2'd2;
	localparam logic [1:0] MS_BA  = 2'd3;

	typedef struct packed {
		logic signed [XW-1:0] ax;
		logic signed [XW-1:0] ay;
		logic signed [XW-1:0] bx;
		logic signed [XW-1:0] by;
		logic                 close;
		logic [CNT_W-1:0]     cnt;
		logic                 too_many;
	} edge_t;

	typedef struct packed {
		logic idle;
		logic emit;
	} back_stat_t;

	typedef enum logic [5:0] {
		B_IDLE = 6'b000001,
		B_MUL  = 6'b000010,
		B_SUM  = 6'b000100,
		B_SQRT = 6'b001000,
		B_ACC  = 6'b010000,
		B_EMIT = 6'b100000
	} back_state_t;

endpackage

// ----- hw/rtl/ppa_if.sv -----
// valid/ready channel interfaces for vertex input and polygon results
// depends on nothing; used by the top level, front and back
interface ppa_vtx_if #(
	parameter int COORD_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] vx;
	logic signed [COORD_BITS-1:0] vy;
	logic                         last_vertex;

	modport source(output valid, output vx, output vy, output last_vertex, input ready);
	modport sink(input valid, input vx, input vy, input last_vertex, output ready);
endinterface

interface ppa_res_if;
	logic        valid;
	logic        ready;
	logic [22:0] perimeter;
	logic [35:0] area_out;
	logic [6:0]  vertex_count;
	logic        overflow;

	modport source(output valid, output perimeter, output area_out, output vertex_count,
		output overflow, input ready);
	modport sink(input valid, input perimeter, input area_out, input vertex_count,
		input overflow, output ready);
endinterface

// ----- hw/rtl/ppa_front.sv -----
// vertex front end: tracks first and previous vertex, counts vertices
// and turns each beat into edge jobs; depends on ppa_pkg and ppa_if
module ppa_front #(
	parameter int MAX_VERTICES = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	ppa_vtx_if.sink         vtx,
	input  logic            fifo_full,
	output logic            push,
	output ppa_pkg::edge_t  push_entry
);

	logic signed [ppa_pkg::XW-1:0] x, y;
	logic signed [ppa_pkg::XW-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic [ppa_pkg::CNT_W-1:0]     cnt_q, cnt_nx;
	logic                          tm_q, tm_nx;
	logic                          pend_q;
	ppa_pkg::edge_t                pend_e_q;
	ppa_pkg::edge_t                close_e, edge_e;
	logic                          acc, at_max, fresh;

	assign x = ppa_pkg::XW'(vtx.vx);
	assign y = ppa_pkg::XW'(vtx.vy);

	assign vtx.ready = !pend_q && !fifo_full;
	assign acc       = vtx.valid && vtx.ready;
	assign at_max    = cnt_q >= ppa_pkg::CNT_W'(MAX_VERTICES);
	assign fresh     = cnt_q == '0;
	assign cnt_nx    = at_max ? cnt_q : cnt_q + ppa_pkg::CNT_W'(1);
	assign tm_nx     = tm_q || at_max;

	always_comb begin
		close_e.ax       = x;
		close_e.ay       = y;
		close_e.bx       = fresh ? x : first_x_q;
		close_e.by       = fresh ? y : first_y_q;
		close_e.close    = 1'b1;
		close_e.cnt      = cnt_nx;
		close_e.too_many = tm_nx;

		edge_e.ax        = prev_x_q;
		edge_e.ay        = prev_y_q;
		edge_e.bx        = x;
		edge_e.by        = y;
		edge_e.close     = 1'b0;
		edge_e.cnt       = cnt_nx;
		edge_e.too_many  = tm_nx;

		if (pend_q) begin
			push       = !fifo_full;
			push_entry = pend_e_q;
		end else begin
			push       = acc && (!fresh || vtx.last_vertex);
			push_entry = fresh ? close_e : edge_e;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_x_q <= '0;
			first_y_q <= '0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			cnt_q     <= '0;
			tm_q      <= 1'b0;
			pend_q    <= 1'b0;
		end else begin
			if (pend_q && !fifo_full) begin
				pend_q <= 1'b0;
			end
			if (acc) begin
				if (fresh) begin
					first_x_q <= x;
					first_y_q <= y;
				end
				prev_x_q <= x;
				prev_y_q <= y;
				if (vtx.last_vertex) begin
					cnt_q <= '0;
					tm_q  <= 1'b0;
					if (!fresh) begin
						pend_q <= 1'b1;
					end
				end else begin
					cnt_q <= cnt_nx;
					tm_q  <= tm_nx;
				end
			end
		end
	end

	// closing edge held while the edge into the last vertex goes first
	always_ff @(posedge clk) begin
		if (acc && vtx.last_vertex && !fresh) begin
			pend_e_q <= close_e;
		end
	end

endmodule

// ----- hw/rtl/ppa_edge_fifo.sv -----
// short queue of edge jobs between the front and the back
// depends on ppa_pkg for the entry type
module ppa_edge_fifo #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ppa_pkg::edge_t din,
	output logic           full,
	input  logic           pop,
	output ppa_pkg::edge_t dout,
	output logic           empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	ppa_pkg::edge_t mem_q [DEPTH];
	logic [AW-1:0]  wptr_q, rptr_q;
	logic [CW-1:0]  count_q;

	assign full  = count_q == CW'(DEPTH);
	assign empty = count_q == '0;
	assign dout  = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= din;
		end
	end

endmodule

// ----- hw/rtl/ppa_back.sv -----
// edge back end: shared multiplier, bit-serial square root, saturating
// perimeter and shoelace sums, result register; depends on ppa_pkg, ppa_if
module ppa_back #(
	parameter int COORD_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fifo_empty,
	input  ppa_pkg::edge_t      fifo_dout,
	output logic                pop,
	output ppa_pkg::back_stat_t stat,
	ppa_res_if.source           res
);

	localparam int XW    = ppa_pkg::XW;
	localparam int DW    = ppa_pkg::DW;
	localparam int PW    = ppa_pkg::PW;
	localparam int ITW   = $clog2(COORD_BITS + 1);
	localparam int SHIFT = 2 * (XW - COORD_BITS);
	localparam int PA_W  = DW + 1;
	localparam int CS_W  = PW + 2;
	localparam int CRW   = ppa_pkg::CROSS_W;

	ppa_pkg::back_state_t state_q;

	logic signed [XW-1:0]      ax_q, ay_q, bx_q, by_q;
	logic signed [DW-1:0]      dx_q, dy_q;
	logic                      close_q, tm_q;
	logic [ppa_pkg::CNT_W-1:0] cnt_q;
	logic [1:0]                mstep_q;
	logic signed [DW-1:0]      ma, mb;
	logic signed [PW-1:0]      prod;
	logic signed [PW-1:0]      sqx_q, sqy_q, cab_q, cba_q;
	logic signed [PW:0]        diff_q;
	logic [PW-1:0]             n_q, sqsum;
	logic [DW-1:0]             root_q;
	logic [DW+1:0]             rem_q, rem_sh, trial;
	logic [ITW-1:0]            iter_q;
	logic [ppa_pkg::PERIM_W-1:0] perim_q, perim_nx;
	logic signed [CRW-1:0]     cross_q, cross_nx;
	logic [PA_W-1:0]           psum;
	logic signed [CS_W-1:0]    csum;
	logic [CRW-1:0]            mag;
	logic [CRW-2:0]            half;
	logic [ppa_pkg::AREA_W-1:0] area;
	logic [ppa_pkg::VCNT_W-1:0] vcnt;
	logic                      res_valid_q, res_free;

	assign pop       = (state_q == ppa_pkg::B_IDLE) && !fifo_empty;
	assign stat.idle = state_q == ppa_pkg::B_IDLE;
	assign stat.emit = state_q == ppa_pkg::B_EMIT;
	assign res_free  = !res_valid_q || res.ready;
	assign res.valid = res_valid_q;

	always_comb begin
		case (mstep_q)
			ppa_pkg::MS_DXX: begin
				ma = dx_q;
				mb = dx_q;
			end
			ppa_pkg::MS_DYY: begin
				ma = dy_q;
				mb = dy_q;
			end
			ppa_pkg::MS_AB: begin
				ma = DW'(ax_q);
				mb = DW'(by_q);
			end
			ppa_pkg::MS_BA: begin
				ma = DW'(bx_q);
				mb = DW'(ay_q);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign prod  = ma * mb;
	assign sqsum = PW'(sqx_q) + PW'(sqy_q);

	// one root bit per cycle
	assign rem_sh = {rem_q[DW-1:0], n_q[PW-1:PW-2]};
	assign trial  = {root_q, 2'b01};

	assign psum     = PA_W'(perim_q) + PA_W'(root_q);
	assign perim_nx = (psum > PA_W'({ppa_pkg::PERIM_W{1'b1}})) ?
		{ppa_pkg::PERIM_W{1'b1}} : psum[ppa_pkg::PERIM_W-1:0];

	assign csum = CS_W'(cross_q) + CS_W'(diff_q);
	always_comb begin
		if ((&csum[CS_W-1:CRW-1]) || !(|csum[CS_W-1:CRW-1])) begin
			cross_nx = csum[CRW-1:0];
		end else if (csum[CS_W-1]) begin
			cross_nx = {1'b1, {(CRW-1){1'b0}}};
		end else begin
			cross_nx = {1'b0, {(CRW-1){1'b1}}};
		end
	end

	assign mag  = cross_q[CRW-1] ? CRW'(-cross_q) : cross_q;
	assign half = mag[CRW-1:1];
	assign area = (|half[CRW-2:ppa_pkg::AREA_W]) ? {ppa_pkg::AREA_W{1'b1}} :
		half[ppa_pkg::AREA_W-1:0];
	assign vcnt = (cnt_q > ppa_pkg::CNT_W'({ppa_pkg::VCNT_W{1'b1}})) ?
		{ppa_pkg::VCNT_W{1'b1}} : cnt_q[ppa_pkg::VCNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ppa_pkg::B_IDLE;
			mstep_q     <= ppa_pkg::MS_DXX;
			iter_q      <= '0;
			perim_q     <= '0;
			cross_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == ppa_pkg::B_EMIT && res_free) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ppa_pkg::B_IDLE: begin
					if (!fifo_empty) begin
						mstep_q <= ppa_pkg::MS_DXX;
						state_q <= ppa_pkg::B_MUL;
					end
				end
				ppa_pkg::B_MUL: begin
					mstep_q <= mstep_q + 2'd1;
					if (mstep_q == ppa_pkg::MS_BA) begin
						state_q <= ppa_pkg::B_SUM;
					end
				end
				ppa_pkg::B_SUM: begin
					iter_q  <= '0;
					state_q <= ppa_pkg::B_SQRT;
				end
				ppa_pkg::B_SQRT: begin
					iter_q <= iter_q + ITW'(1);
					if (iter_q == ITW'(COORD_BITS)) begin
						state_q <= ppa_pkg::B_ACC;
					end
				end
				ppa_pkg::B_ACC: begin
					perim_q <= perim_nx;
					cross_q <= cross_nx;
					state_q <= close_q ? ppa_pkg::B_EMIT : ppa_pkg::B_IDLE;
				end
				ppa_pkg::B_EMIT: begin
					if (res_free) begin
						perim_q <= '0;
						cross_q <= '0;
						state_q <= ppa_pkg::B_IDLE;
					end
				end
				default: begin
					state_q <= ppa_pkg::B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ax_q    <= fifo_dout.ax;
			ay_q    <= fifo_dout.ay;
			bx_q    <= fifo_dout.bx;
			by_q    <= fifo_dout.by;
			dx_q    <= DW'(fifo_dout.bx) - DW'(fifo_dout.ax);
			dy_q    <= DW'(fifo_dout.by) - DW'(fifo_dout.ay);
			close_q <= fifo_dout.close;
			cnt_q   <= fifo_dout.cnt;
			tm_q    <= fifo_dout.too_many;
		end
		if (state_q == ppa_pkg::B_MUL) begin
			case (mstep_q)
				ppa_pkg::MS_DXX: sqx_q <= prod;
				ppa_pkg::MS_DYY: sqy_q <= prod;
				ppa_pkg::MS_AB:  cab_q <= prod;
				ppa_pkg::MS_BA:  cba_q <= prod;
				default: begin
				end
			endcase
		end
		if (state_q == ppa_pkg::B_SUM) begin
			diff_q <= (PW+1)'(cab_q) - (PW+1)'(cba_q);
			n_q    <= sqsum << SHIFT;
			root_q <= '0;
			rem_q  <= '0;
		end
		if (state_q == ppa_pkg::B_SQRT) begin
			n_q <= {n_q[PW-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[DW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[DW-2:0], 1'b0};
			end
		end
		if (state_q == ppa_pkg::B_EMIT && res_free) begin
			res.perimeter    <= perim_q;
			res.area_out     <= area;
			res.vertex_count <= vcnt;
			res.overflow     <= tm_q;
		end
	end

endmodule

// ----- hw/rtl/polygon_perimeter_and_area.sv -----
// top level of the polygon perimeter and shoelace area block
// depends on ppa_pkg, ppa_if, ppa_front, ppa_edge_fifo, ppa_back
//
// channel  dir  beat
// vtx      in   one vertex: vx, vy, last_vertex
// res      out  one polygon: perimeter, area_out, vertex_count, overflow
//
// each edge passes through the back in four multiplier steps and a square root
// found one root bit a cycle; one edge per vertex
// a last vertex adds the closing edge and the loading of the result
// the edge queue lets vertices arrive while the back still works
// reset clears all control state at once; no clearing pass
// a stalled result holds the back at its closing edge only
module polygon_perimeter_and_area #(
	parameter int MAX_VERTICES = 64,
	parameter int COORD_BITS   = 16,
	parameter int FIFO_DEPTH   = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	ppa_vtx_if.sink   vtx,
	ppa_res_if.source res
);

	`include "assert_macros.svh"

	logic                push, pop, fifo_full, fifo_empty;
	ppa_pkg::edge_t      push_entry, fifo_dout;
	ppa_pkg::back_stat_t bstat;

	ppa_front #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.vtx       (vtx),
		.fifo_full (fifo_full),
		.push      (push),
		.push_entry(push_entry)
	);

	ppa_edge_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (push_entry),
		.full  (fifo_full),
		.pop   (pop),
		.dout  (fifo_dout),
		.empty (fifo_empty)
	);

	ppa_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.fifo_empty(fifo_empty),
		.fifo_dout (fifo_dout),
		.pop       (pop),
		.stat      (bstat),
		.res       (res)
	);

	`PPA_ASSERT_NEVER(a_push_full, clk, arst_n, push && fifo_full)
	`PPA_ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && fifo_empty)
	`PPA_ASSERT(a_pop_idle, clk, arst_n, pop |-> bstat.idle)
	`PPA_ASSERT(a_res_after_emit, clk, arst_n, $rose(res.valid) |-> $past(bstat.emit))

endmodule

// ----- verif/ppa_shape_check.sv -----
// checker for the polygon perimeter and area block: watches both channels,
// predicts each polygon result and compares it field by field
// depends on ppa_pkg and the ppa_vtx_if / ppa_res_if interfaces
`timescale 1ns / 100ps

module ppa_shape_check #(
	parameter int MAX_VERTICES = 64
) (
	input  logic clk,
	input  logic arst_n,
	ppa_vtx_if   vtx,
	ppa_res_if   res,
	output int   fail_count,
	output int   pending_count,
	output int   vertices_seen,
	output int   polygons_seen,
	output int   bound_hits
);

	localparam longint unsigned PERIM_MAX = (64'd1 << ppa_pkg::PERIM_W) - 1;
	localparam longint unsigned AREA_MAX  = (64'd1 << ppa_pkg::AREA_W) - 1;
	localparam longint          CROSS_MAX = (64'sd1 <<< (ppa_pkg::CROSS_W - 1)) - 1;
	localparam longint          CROSS_MIN = -(64'sd1 <<< (ppa_pkg::CROSS_W - 1));
	localparam int unsigned     COUNT_CAP = (1 << ppa_pkg::VCNT_W) - 1;

	typedef struct packed {
		logic [ppa_pkg::PERIM_W-1:0] perimeter;
		logic [ppa_pkg::AREA_W-1:0]  area;
		logic [ppa_pkg::VCNT_W-1:0]  count;
		logic                        overflow;
	} poly_result_t;

	poly_result_t pending_polys[$];

	// running shape state
	longint          first_x = 0, first_y = 0, prev_x = 0, prev_y = 0;
	longint unsigned perim_acc = 0;
	longint          cross_acc = 0;
	int unsigned     verts_in_shape = 0;
	bit              past_bound = 1'b0;

	int n_fail = 0, n_pending = 0, n_verts = 0, n_polys = 0, n_bound = 0;

	assign fail_count    = n_fail;
	assign pending_count = n_pending;
	assign vertices_seen = n_verts;
	assign polygons_seen = n_polys;
	assign bound_hits    = n_bound;

	function automatic longint unsigned floor_root(input longint unsigned n);
		longint unsigned rem, root, b;
		rem = n;
		root = 0;
		b = 64'd1 << 62;
		while (b > rem)
			b >>= 2;
		while (b != 0) begin
			if (rem >= root + b) begin
				rem -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	task automatic add_side(input longint ax, input longint ay, input longint bx,
		input longint by);
		longint dx, dy, c;
		longint unsigned sq, p;
		dx = bx - ax;
		dy = by - ay;
		if (dx < 0)
			dx = -dx;
		if (dy < 0)
			dy = -dy;
		sq = dx * dx + dy * dy;
		p = perim_acc + floor_root(sq);
		perim_acc = (p > PERIM_MAX) ? PERIM_MAX : p;
		c = cross_acc + (ax * by - bx * ay);
		if (c > CROSS_MAX)
			c = CROSS_MAX;
		if (c < CROSS_MIN)
			c = CROSS_MIN;
		cross_acc = c;
	endtask

	task automatic take_vertex(input longint x, input longint y, input bit closes);
		poly_result_t want;
		longint unsigned mag, half;
		if (verts_in_shape == 0) begin
			first_x = x;
			first_y = y;
		end else begin
			add_side(prev_x, prev_y, x, y);
		end
		prev_x = x;
		prev_y = y;
		if (verts_in_shape < MAX_VERTICES)
			verts_in_shape++;
		else
			past_bound = 1'b1;
		if (closes) begin
			add_side(x, y, first_x, first_y);
			mag = (cross_acc < 0) ? -cross_acc : cross_acc;
			half = mag >> 1;
			if (half > AREA_MAX)
				half = AREA_MAX;
			want.perimeter = perim_acc[ppa_pkg::PERIM_W-1:0];
			want.area      = half[ppa_pkg::AREA_W-1:0];
			want.count     = ppa_pkg::VCNT_W'((verts_in_shape > COUNT_CAP) ?
				COUNT_CAP : verts_in_shape);
			want.overflow  = past_bound;
			pending_polys.push_back(want);
			n_pending++;
			if (past_bound)
				n_bound++;
			first_x = 0;
			first_y = 0;
			prev_x = 0;
			prev_y = 0;
			perim_acc = 0;
			cross_acc = 0;
			verts_in_shape = 0;
			past_bound = 1'b0;
		end
	endtask

	always @(posedge clk) begin
		poly_result_t want;
		if (arst_n) begin
			if (vtx.valid && vtx.ready) begin
				n_verts++;
				take_vertex(vtx.vx, vtx.vy, vtx.last_vertex);
			end
			if (res.valid && res.ready) begin
				if (pending_polys.size() == 0) begin
					$error("result beat with no polygon pending");
					n_fail++;
				end else begin
					want = pending_polys.pop_front();
					n_pending--;
					n_polys++;
					if (res.perimeter !== want.perimeter) begin
						$error("perimeter: expected %0d, got %0d", want.perimeter,
							res.perimeter);
						n_fail++;
					end
					if (res.area_out !== want.area) begin
						$error("area_out: expected %0d, got %0d", want.area,
							res.area_out);
						n_fail++;
					end
					if (res.vertex_count !== want.count) begin
						$error("vertex_count: expected %0d, got %0d", want.count,
							res.vertex_count);
						n_fail++;
					end
					if (res.overflow !== want.overflow) begin
						$error("overflow: expected %0d, got %0d", want.overflow,
							res.overflow);
						n_fail++;
					end
				end
			end
		end
	end

endmodule

// ----- verif/tb.sv -----
// testbench top for polygon_perimeter_and_area: clock, reset, vertex stimulus,
// result back-pressure and the verdict; checking lives in ppa_shape_check
// depends on ppa_pkg, the ppa interfaces, the block and ppa_shape_check
`timescale 1ns / 100ps

module tb;

	localparam int MAX_VERTICES = 64;
	localparam int COORD_BITS   = 16;
	localparam int PHASE_ITEMS  = 270;
	localparam int HOLD_CYCLES  = 4000;

	typedef enum int {
		SPREAD_FULL,
		SPREAD_SMALL,
		SPREAD_EDGE,
		SPREAD_MID,
		SPREAD_MIXED
	} spread_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	int send_idle_pct = 14;
	int recv_idle_pct = 73;
	int phase_no = 0;
	bit hold_rx = 1'b0;

	int fails, pending, verts, polys, bound_hits;

	ppa_vtx_if #(.COORD_BITS(COORD_BITS)) vtx_ch ();
	ppa_res_if res_ch ();

	polygon_perimeter_and_area #(
		.MAX_VERTICES(MAX_VERTICES),
		.COORD_BITS  (COORD_BITS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.vtx   (vtx_ch),
		.res   (res_ch)
	);

	ppa_shape_check #(.MAX_VERTICES(MAX_VERTICES)) shape_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.vtx          (vtx_ch),
		.res          (res_ch),
		.fail_count   (fails),
		.pending_count(pending),
		.vertices_seen(verts),
		.polygons_seen(polys),
		.bound_hits   (bound_hits)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	function automatic logic signed [COORD_BITS-1:0] pick_coord(input spread_t spread);
		spread_t s;
		s = (spread == SPREAD_MIXED) ? spread_t'($urandom_range(3)) : spread;
		case (s)
			SPREAD_SMALL: return COORD_BITS'($urandom_range(128) - 64);
			SPREAD_EDGE: begin
				case ($urandom_range(4))
					0: return COORD_BITS'(-32768);
					1: return COORD_BITS'(32767);
					2: return COORD_BITS'(0);
					3: return COORD_BITS'(-1);
					default: return COORD_BITS'(1);
				endcase
			end
			SPREAD_MID: return COORD_BITS'($urandom_range(4095) - 2048);
			default: return COORD_BITS'($urandom_range(65535));
		endcase
	endfunction

	task automatic push_vertex(input logic signed [COORD_BITS-1:0] x,
		input logic signed [COORD_BITS-1:0] y, input bit closes);
		while ($urandom_range(99) < send_idle_pct) begin
			vtx_ch.valid <= 1'b0;
			@(negedge clk);
		end
		vtx_ch.valid <= 1'b1;
		vtx_ch.vx <= x;
		vtx_ch.vy <= y;
		vtx_ch.last_vertex <= closes;
		do @(posedge clk); while (!vtx_ch.ready);
		@(negedge clk);
	endtask

	task automatic send_shape(input int size, input spread_t spread);
		for (int i = 0; i < size; i++)
			push_vertex(pick_coord(spread), pick_coord(spread), i == size - 1);
	endtask

	// laps around the full-range square: each edge of a lap pushes the cross sum one way,
	// so the perimeter and cross sums saturate and the vertex bound is passed
	task automatic send_winding(input int size, input bit ccw);
		logic signed [COORD_BITS-1:0] cx[4], cy[4];
		int k;
		cx = '{32767, 32767, -32768, -32768};
		cy = '{-32768, 32767, 32767, -32768};
		for (int i = 0; i < size; i++) begin
			k = ccw ? (i % 4) : ((4 - (i % 4)) % 4);
			push_vertex(cx[k], cy[k], i == size - 1);
		end
	endtask

	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			res_ch.ready <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// long receiver hold while the sender keeps offering vertices
	initial begin
		wait (phase_no == 2);
		repeat (40) @(negedge clk);
		hold_rx <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_rx <= 1'b0;
	end

	initial begin
		int sent;
		int r;
		int size;
		vtx_ch.valid = 1'b0;
		vtx_ch.vx = '0;
		vtx_ch.vy = '0;
		vtx_ch.last_vertex = 1'b0;
		wait (arst_n);
		@(negedge clk);

		// lone vertices
		push_vertex(-32768, 32767, 1'b1);
		push_vertex(0, 0, 1'b1);
		// two vertices, the edge is walked both ways
		push_vertex(-1, -1, 1'b0);
		push_vertex(1, 1, 1'b1);
		// full-range triangle
		push_vertex(-32768, -32768, 1'b0);
		push_vertex(32767, -32768, 1'b0);
		push_vertex(32767, 32767, 1'b1);
		// 16 by 16 square in both directions
		push_vertex(0, 0, 1'b0);
		push_vertex(16, 0, 1'b0);
		push_vertex(16, 16, 1'b0);
		push_vertex(0, 16, 1'b1);
		push_vertex(0, 0, 1'b0);
		push_vertex(0, 16, 1'b0);
		push_vertex(16, 16, 1'b0);
		push_vertex(16, 0, 1'b1);
		// collinear, zero area
		push_vertex(-5, -5, 1'b0);
		push_vertex(3, 3, 1'b0);
		push_vertex(11, 11, 1'b1);
		// repeated vertex
		push_vertex(7, -9, 1'b0);
		push_vertex(7, -9, 1'b0);
		push_vertex(-100, 200, 1'b1);

		for (int ph = 0; ph < 3; ph++) begin
			phase_no = ph;
			case (ph)
				0: begin
					send_idle_pct = 14;
					recv_idle_pct <= 73;
				end
				1: begin
					send_idle_pct = 73;
					recv_idle_pct <= 14;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct <= 0;
				end
			endcase
			sent = 0;
			if (ph < 2) begin
				size = $urandom_range(130, 160);
				send_winding(size, ph == 0);
				sent += size;
			end
			while (sent < PHASE_ITEMS) begin
				r = $urandom_range(99);
				if (r < 8)
					size = $urandom_range(60, 70);
				else if (r < 15)
					size = $urandom_range(11, 40);
				else
					size = $urandom_range(1, 10);
				send_shape(size, spread_t'($urandom_range(4)));
				sent += size;
			end
		end
		vtx_ch.valid <= 1'b0;

		wait (pending == 0);
		repeat (60) @(negedge clk);
		$display("checked %0d polygons from %0d vertices, %0d past the vertex bound",
			polys, verts, bound_hits);
		$display("sender/receiver idle 14/73, 73/14, 0/0 percent, one %0d-cycle hold",
			HOLD_CYCLES);
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("timeout with %0d polygons still outstanding", pending);
		$display("Regression FAIL");
		$finish;
	end

endmodule
